// ----- design/rbf_pkg.sv -----
// ----------------------------------------------------------------------------
// rbf_pkg : shared types and constants of the resonant biquad filter
// Widths, codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package rbf_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int GROUP_SIZE   = 4;
    localparam int PHASE_W      = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;

    localparam int FREQ_BITS    = 24;
    localparam int Q_BITS       = 32;
    localparam int DELAY_BITS   = 40;
    localparam int ALPHA_BITS   = 40;
    localparam int RECIP_BITS   = 32;
    localparam int L2_BITS      = 31;
    localparam int COEF_BITS    = 34;
    localparam int SIG_BITS     = 42;
    localparam int ACC_BITS     = 48;
    localparam int MUL_A_BITS   = 33;
    localparam int MUL_B_BITS   = 32;
    localparam int PROD_BITS    = MUL_A_BITS + MUL_B_BITS;
    localparam int DIV_N_BITS   = 48;
    localparam int DIV_D_BITS   = 41;
    localparam int DIV_CNT_BITS = $clog2(DIV_N_BITS + 1);

    localparam logic [MUL_B_BITS-1:0] FLOOR_GAIN = 32'd1000000;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_FILTER_TYPE = 3'd0;
    localparam logic [2:0] REG_FREQ_SRC    = 3'd1;
    localparam logic [2:0] REG_Q_SRC       = 3'd2;
    localparam logic [2:0] REG_FIXED_FREQ  = 3'd3;
    localparam logic [2:0] REG_FIXED_Q     = 3'd4;

    typedef enum logic [1:0] {
        FT_BANDPASS,
        FT_RESONANT,
        FT_LOWPASS,
        FT_HIGHPASS
    } filter_type_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ,
        OP_L2,
        OP_FLOOR_MUL,
        OP_ALPHA_SAT,
        OP_DIV_ALPHA,
        OP_ALPHA_Q,
        OP_DIV_RCP,
        OP_RCP_Q,
        OP_T_MUL,
        OP_T,
        OP_COEF,
        OP_MQ_LO,
        OP_MQ_HI,
        OP_MQ_ACC,
        OP_W0,
        OP_GAIN_MUL,
        OP_GAIN,
        OP_SHIFT
    } op_t;

    typedef enum logic [1:0] {
        MQ_FB1,
        MQ_FB2,
        MQ_OUT
    } mq_sel_t;

    typedef struct packed {
        op_t     op;
        mq_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic q_zero;
    } status_t;

endpackage

// ----- design/rbf_div.sv -----
// ----------------------------------------------------------------------------
// rbf_div : iterative unsigned divider
// Restoring division, one quotient bit per cycle, DIV_N_BITS quotient bits.
// ----------------------------------------------------------------------------
module rbf_div
    import rbf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIV_N_BITS-1:0] num,
    input  logic [DIV_D_BITS-1:0] den,
    output logic                  done,
    output logic [DIV_N_BITS-1:0] quot
);

    logic [DIV_N_BITS-1:0]   work_reg;
    logic [DIV_D_BITS-1:0]   rem_reg;
    logic [DIV_D_BITS-1:0]   den_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic [DIV_D_BITS:0]     rem_sh;
    logic [DIV_D_BITS+1:0]   diff;
    logic                    ge;

    always_comb
    begin
        rem_sh = {rem_reg, work_reg[DIV_N_BITS-1]};
        diff   = {1'b0, rem_sh} - {2'b0, den_reg};
        ge     = ~diff[DIV_D_BITS+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_BITS'(DIV_N_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where numerator bits shift out
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= num;
            den_reg  <= den;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[DIV_N_BITS-2:0], ge};
            rem_reg  <= ge ? diff[DIV_D_BITS-1:0] : rem_sh[DIV_D_BITS-1:0];
        end
    end

    assign done = done_reg;
    assign quot = work_reg;

endmodule

// ----- design/rbf_datapath.sv -----
// ----------------------------------------------------------------------------
// rbf_datapath : biquad arithmetic
// Shared 33x32 multiplier, divider, delay line and held coefficients.
// ----------------------------------------------------------------------------
module rbf_datapath
    import rbf_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    output status_t                       status,
    input  filter_type_t                  filter_type,
    input  logic                          freq_from_signal,
    input  logic                          q_from_signal,
    input  logic signed [FREQ_BITS-1:0]   fixed_freq,
    input  logic [Q_BITS-1:0]             fixed_q,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [FREQ_BITS-1:0]   freq_sample,
    input  logic [Q_BITS-1:0]             q_sample,
    output logic signed [SAMPLE_BITS-1:0] filtered
);

    localparam logic signed [ACC_BITS-1:0] W_MAX =
        {{(ACC_BITS-DELAY_BITS+1){1'b0}}, {(DELAY_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] W_MIN = ~W_MAX;
    localparam logic signed [ACC_BITS-1:0] Y_MAX =
        {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] Y_MIN = ~Y_MAX;
    localparam logic signed [COEF_BITS-1:0] ONE_Q30 = COEF_BITS'(1) << 30;

    // held state
    logic signed [DELAY_BITS-1:0]  w1_reg, w2_reg;
    logic [FREQ_BITS-1:0]          held_freq_reg;
    logic [ALPHA_BITS-1:0]         held_alpha_reg;
    logic [RECIP_BITS-1:0]         held_recip_reg;
    logic [L2_BITS-1:0]            l2_reg;

    // working registers
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [FREQ_BITS-1:0]          cand_l_reg;
    logic [Q_BITS-1:0]             cand_q_reg;
    logic [L2_BITS-1:0]            t_reg;
    logic signed [COEF_BITS-1:0]   a1_reg, a2_reg, gain_reg;
    logic signed [SIG_BITS-1:0]    sig_reg;
    logic [PROD_BITS-1:0]          prod_reg;
    logic [33:0]                   plo_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic signed [DELAY_BITS-1:0]  w0_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic signed [SAMPLE_BITS-1:0] filtered_reg;

    logic signed [FREQ_BITS-1:0]   f_sel;
    logic [FREQ_BITS-1:0]          l_abs;
    logic [MUL_A_BITS-1:0]         mul_a;
    logic [MUL_B_BITS-1:0]         mul_b;
    logic [PROD_BITS-1:0]          mul_p;
    logic signed [COEF_BITS-1:0]   op_a, ua_full;
    logic signed [SIG_BITS-1:0]    op_w, uw_full;
    logic [MUL_A_BITS-1:0]         ua;
    logic [SIG_BITS-1:0]           uw;
    logic                          neg;
    logic [55:0]                   mq_sum;
    logic [45:0]                   mq_r;
    logic signed [ACC_BITS-1:0]    sr;
    logic signed [ACC_BITS-1:0]    w0_diff;
    logic signed [ACC_BITS-1:0]    w0_sat, y_sat;
    logic signed [COEF_BITS-1:0]   gain_c;
    logic signed [SIG_BITS-1:0]    sig_c, w0e, w1e, w2e;
    logic                          div_start, div_done;
    logic [DIV_N_BITS-1:0]         div_num, div_quot;
    logic [DIV_D_BITS-1:0]         div_den;

    always_comb
    begin
        f_sel = freq_from_signal ? freq_sample : fixed_freq;
        l_abs = f_sel[FREQ_BITS-1] ? (FREQ_BITS'(0) - f_sel) : f_sel;
    end

    // operand pair of the current mulq30 pass
    always_comb
    begin
        case (cmd.sel)
            MQ_FB1:
            begin
                op_a = a1_reg;
                op_w = SIG_BITS'(w1_reg);
            end
            MQ_FB2:
            begin
                op_a = a2_reg;
                op_w = SIG_BITS'(w2_reg);
            end
            default:
            begin
                op_a = gain_reg;
                op_w = sig_reg;
            end
        endcase
        ua_full = op_a[COEF_BITS-1] ? -op_a : op_a;
        uw_full = op_w[SIG_BITS-1] ? -op_w : op_w;
        ua      = ua_full[MUL_A_BITS-1:0];
        uw      = uw_full;
        neg     = op_a[COEF_BITS-1] ^ op_w[SIG_BITS-1];
        mq_sum  = prod_reg[55:0] + {22'b0, plo_reg};
        mq_r    = mq_sum[55:10];
        sr      = neg ? -$signed({2'b0, mq_r}) : $signed({2'b0, mq_r});
    end

    always_comb
    begin
        case (cmd.op)
            OP_SQ:
            begin
                mul_a = {9'b0, cand_l_reg};
                mul_b = {8'b0, cand_l_reg};
            end
            OP_FLOOR_MUL:
            begin
                mul_a = {9'b0, cand_l_reg};
                mul_b = FLOOR_GAIN;
            end
            OP_T_MUL:
            begin
                mul_a = {1'b0, held_recip_reg};
                mul_b = {1'b0, l2_reg};
            end
            OP_GAIN_MUL:
            begin
                mul_a = {1'b0, held_recip_reg};
                mul_b = {8'b0, held_freq_reg};
            end
            OP_MQ_LO:
            begin
                mul_a = ua;
                mul_b = {12'b0, uw[19:0]};
            end
            OP_MQ_HI:
            begin
                mul_a = ua;
                mul_b = {10'b0, uw[41:20]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // saturation and response selection
    always_comb
    begin
        w0_diff = ACC_BITS'(x_reg) - acc_reg;
        if (w0_diff > W_MAX)
            w0_sat = W_MAX;
        else if (w0_diff < W_MIN)
            w0_sat = W_MIN;
        else
            w0_sat = w0_diff;

        if (sr > Y_MAX)
            y_sat = Y_MAX;
        else if (sr < Y_MIN)
            y_sat = Y_MIN;
        else
            y_sat = sr;

        w0e = SIG_BITS'(w0_reg);
        w1e = SIG_BITS'(w1_reg);
        w2e = SIG_BITS'(w2_reg);
        case (filter_type)
            FT_BANDPASS:
            begin
                gain_c = ONE_Q30 - $signed({3'b0, t_reg});
                sig_c  = w0e - w2e;
            end
            FT_RESONANT:
            begin
                gain_c = $signed(prod_reg[50:17]);
                sig_c  = w0e - w2e;
            end
            FT_LOWPASS:
            begin
                gain_c = $signed({3'b0, held_recip_reg[RECIP_BITS-1:1]});
                sig_c  = w0e + (w1e <<< 1) + w2e;
            end
            FT_HIGHPASS:
            begin
                gain_c = $signed({3'b0, t_reg})
                       - $signed({3'b0, held_recip_reg[RECIP_BITS-1:1]});
                sig_c  = w0e - (w1e <<< 1) + w2e;
            end
        endcase
    end

    always_comb
    begin
        div_start = (cmd.op == OP_DIV_ALPHA) || (cmd.op == OP_DIV_RCP);
        if (cmd.op == OP_DIV_RCP)
        begin
            div_num = {1'b1, {(DIV_N_BITS-1){1'b0}}};
            div_den = {1'b0, held_alpha_reg} + {10'b0, l2_reg};
        end
        else
        begin
            div_num = {8'b0, cand_l_reg, 16'b0};
            div_den = {9'b0, cand_q_reg};
        end
    end

    rbf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // filter state: delays and held coefficients
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_reg         <= '0;
            w2_reg         <= '0;
            held_freq_reg  <= '0;
            held_alpha_reg <= '0;
            held_recip_reg <= '0;
            l2_reg         <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_L2:
                begin
                    held_freq_reg <= cand_l_reg;
                    l2_reg        <= prod_reg[46:16] + L2_BITS'(65536);
                end
                OP_ALPHA_SAT:
                    held_alpha_reg <= (|prod_reg[PROD_BITS-1:ALPHA_BITS]) ? '1
                                    : prod_reg[ALPHA_BITS-1:0];
                OP_ALPHA_Q:
                    held_alpha_reg <= div_quot[ALPHA_BITS-1:0];
                OP_RCP_Q:
                    held_recip_reg <= div_quot[RECIP_BITS-1:0];
                OP_SHIFT:
                begin
                    w2_reg <= w1_reg;
                    w1_reg <= w0_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                x_reg      <= sample;
                cand_l_reg <= l_abs;
                cand_q_reg <= q_from_signal ? q_sample : fixed_q;
            end
            OP_SQ, OP_FLOOR_MUL, OP_T_MUL, OP_GAIN_MUL, OP_MQ_LO:
                prod_reg <= mul_p;
            OP_MQ_HI:
            begin
                plo_reg  <= prod_reg[53:20];
                prod_reg <= mul_p;
            end
            OP_T:
                t_reg <= prod_reg[47:17];
            OP_COEF:
            begin
                a1_reg  <= $signed({1'b0, held_recip_reg, 1'b0})
                         - $signed({2'b0, t_reg, 1'b0});
                a2_reg  <= $signed({2'b0, t_reg, 1'b0}) - ONE_Q30;
                acc_reg <= '0;
            end
            OP_MQ_ACC:
            begin
                if (cmd.sel == MQ_OUT)
                    y_reg <= y_sat[SAMPLE_BITS-1:0];
                else
                    acc_reg <= acc_reg + sr;
            end
            OP_W0:
                w0_reg <= w0_sat[DELAY_BITS-1:0];
            OP_GAIN:
            begin
                gain_reg <= gain_c;
                sig_reg  <= sig_c;
            end
            OP_SHIFT:
                filtered_reg <= y_reg;
            default:
            begin
            end
        endcase
    end

    assign status.div_done = div_done;
    assign status.q_zero   = (cand_q_reg == '0);
    assign filtered        = filtered_reg;

endmodule

// ----- design/rbf_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbf_ctrl : sequencer of the biquad datapath
// Steps each sample through latch (first of a group), feedback and output passes.
// ----------------------------------------------------------------------------
module rbf_ctrl
    import rbf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    vector_start,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd,
    output logic    in_stall,
    output logic    out_valid
);

    typedef enum logic [4:0] {
        S_IDLE, S_SQ, S_L2, S_FMUL, S_ASAT, S_DIVA, S_WAITA, S_DIVR, S_WAITR,
        S_TMUL, S_T, S_COEF, S_F1LO, S_F1HI, S_F1AC, S_F2LO, S_F2HI, S_F2AC,
        S_W0, S_GMUL, S_GAIN, S_YLO, S_YHI, S_YAC, S_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next, phase_base;
    logic                 out_valid_reg, out_valid_next;
    logic                 accept, latch, out_free;

    always_comb
    begin
        accept     = in_valid && (state_reg == S_IDLE);
        phase_base = vector_start ? '0 : phase_reg;
        latch      = vector_start || (phase_reg == '0);
        out_free   = !out_valid_reg || !out_stall;

        phase_next = phase_reg;
        if (accept)
            phase_next = (phase_base == PHASE_W'(GROUP_SIZE - 1)) ? '0
                       : phase_base + 1'b1;

        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (state_reg == S_OUT && out_free)
            out_valid_next = 1'b1;

        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = MQ_FB1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = latch ? S_SQ : S_TMUL;
                end
            end
            S_SQ:    begin cmd.op = OP_SQ;  state_next = S_L2; end
            S_L2:
            begin
                cmd.op     = OP_L2;
                state_next = status.q_zero ? S_FMUL : S_DIVA;
            end
            S_FMUL:  begin cmd.op = OP_FLOOR_MUL; state_next = S_ASAT; end
            S_ASAT:  begin cmd.op = OP_ALPHA_SAT; state_next = S_DIVR; end
            S_DIVA:  begin cmd.op = OP_DIV_ALPHA; state_next = S_WAITA; end
            S_WAITA:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_ALPHA_Q;
                    state_next = S_DIVR;
                end
            end
            S_DIVR:  begin cmd.op = OP_DIV_RCP; state_next = S_WAITR; end
            S_WAITR:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_RCP_Q;
                    state_next = S_TMUL;
                end
            end
            S_TMUL:  begin cmd.op = OP_T_MUL; state_next = S_T; end
            S_T:     begin cmd.op = OP_T;     state_next = S_COEF; end
            S_COEF:  begin cmd.op = OP_COEF;  state_next = S_F1LO; end
            S_F1LO:  begin cmd.op = OP_MQ_LO;  cmd.sel = MQ_FB1; state_next = S_F1HI; end
            S_F1HI:  begin cmd.op = OP_MQ_HI;  cmd.sel = MQ_FB1; state_next = S_F1AC; end
            S_F1AC:  begin cmd.op = OP_MQ_ACC; cmd.sel = MQ_FB1; state_next = S_F2LO; end
            S_F2LO:  begin cmd.op = OP_MQ_LO;  cmd.sel = MQ_FB2; state_next = S_F2HI; end
            S_F2HI:  begin cmd.op = OP_MQ_HI;  cmd.sel = MQ_FB2; state_next = S_F2AC; end
            S_F2AC:  begin cmd.op = OP_MQ_ACC; cmd.sel = MQ_FB2; state_next = S_W0; end
            S_W0:    begin cmd.op = OP_W0;       state_next = S_GMUL; end
            S_GMUL:  begin cmd.op = OP_GAIN_MUL; state_next = S_GAIN; end
            S_GAIN:  begin cmd.op = OP_GAIN;     state_next = S_YLO; end
            S_YLO:   begin cmd.op = OP_MQ_LO;  cmd.sel = MQ_OUT; state_next = S_YHI; end
            S_YHI:   begin cmd.op = OP_MQ_HI;  cmd.sel = MQ_OUT; state_next = S_YAC; end
            S_YAC:   begin cmd.op = OP_MQ_ACC; cmd.sel = MQ_OUT; state_next = S_OUT; end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.op     = OP_SHIFT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    a_wait_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAITA && !status.div_done) |=> state_reg == S_WAITA)
        else $error("left divider wait before quotient ready");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == S_WAITA || state_reg == S_WAITR))
        else $error("divider finished outside a wait step");

    a_vector_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && vector_start) |=> phase_reg == PHASE_W'(1 % GROUP_SIZE))
        else $error("grouping did not restart at vector start");

endmodule

// ----- design/resonant_biquad_filter_core.sv -----
// ----------------------------------------------------------------------------
// resonant_biquad_filter_core : two-pole resonant filter, one sample a transaction
// Top level: APB register file, sequencer and fixed-point datapath.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_stall) takes sample, freq_sample, q_sample and
//   vector_start; a transaction completes when in_valid is high and in_stall
//   low. Output channel (out_valid/out_stall) returns one filtered sample per
//   input transaction, held in an output register until taken.
//   One sample is processed at a time by a single shared 33x32 multiplier.
//   A sample that reuses the held coefficients goes straight from acceptance
//   to the coefficient, feedback and output steps; the next sample can be
//   taken once out_valid rises. The first sample of each group of four (or
//   one flagged by vector_start) also latches coefficients: two bit-serial
//   divisions of 48 steps (damping and reciprocal), each with a start and a
//   hand-back step; when Q is zero the damping division is skipped.
//   A new sample is accepted once the previous one has been written to the
//   output register, even while that result still waits to be taken.
//   When the receiver stalls with a result pending, the next sample stops
//   at its final step until the output register frees.
//   Reset clears registers, delays, held coefficients and the grouping, so
//   the first sample after reset always latches coefficients.
//   Registers (byte address 4*i): filter_type, freq_from_signal,
//   q_from_signal, fixed_freq, fixed_q; write only while idle. pready is
//   tied high.
// ----------------------------------------------------------------------------
module resonant_biquad_filter_core
    import rbf_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [FREQ_BITS-1:0]   freq_sample,
    input  logic [Q_BITS-1:0]             q_sample,
    input  logic                          vector_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] filtered
);

    filter_type_t                filter_type_reg;
    logic                        freq_src_reg;
    logic                        q_src_reg;
    logic signed [FREQ_BITS-1:0] fixed_freq_reg;
    logic [Q_BITS-1:0]           fixed_q_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;
    cmd_t       cmd;
    status_t    status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    // register file; writes outside the map are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_type_reg <= FT_BANDPASS;
            freq_src_reg    <= 1'b0;
            q_src_reg       <= 1'b0;
            fixed_freq_reg  <= '0;
            fixed_q_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FILTER_TYPE: filter_type_reg <= filter_type_t'(pwdata[1:0]);
                REG_FREQ_SRC:    freq_src_reg    <= pwdata[0];
                REG_Q_SRC:       q_src_reg       <= pwdata[0];
                REG_FIXED_FREQ:  fixed_freq_reg  <= pwdata[FREQ_BITS-1:0];
                REG_FIXED_Q:     fixed_q_reg     <= pwdata[Q_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // read-back, zero extended
    always_comb
    begin
        unique case (cfg_index)
            REG_FILTER_TYPE: prdata = {30'b0, filter_type_reg};
            REG_FREQ_SRC:    prdata = {31'b0, freq_src_reg};
            REG_Q_SRC:       prdata = {31'b0, q_src_reg};
            REG_FIXED_FREQ:  prdata = {8'b0, fixed_freq_reg};
            REG_FIXED_Q:     prdata = fixed_q_reg;
            default:         prdata = '0;
        endcase
    end

    rbf_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .vector_start (vector_start),
        .out_stall    (out_stall),
        .status       (status),
        .cmd          (cmd),
        .in_stall     (in_stall),
        .out_valid    (out_valid)
    );

    rbf_datapath u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .filter_type      (filter_type_reg),
        .freq_from_signal (freq_src_reg),
        .q_from_signal    (q_src_reg),
        .fixed_freq       (fixed_freq_reg),
        .fixed_q          (fixed_q_reg),
        .sample           (sample),
        .freq_sample      (freq_sample),
        .q_sample         (q_sample),
        .filtered         (filtered)
    );

endmodule
